// ----- src/dasl_pkg.sv -----
// Shared types and constants for the dual axis servo slew limiter.
// No dependencies.
package dasl_pkg;

  localparam int ANGLE_W = 12;
  localparam int TARGET_W = 13;
  localparam int PULSE_W = 12;
  localparam int TICK_W = 8;
  localparam int CMD_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;

  typedef logic [ANGLE_W-1:0] angle_t;
  typedef logic signed [TARGET_W-1:0] target_t;
  typedef logic [PULSE_W-1:0] pulse_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cmd_t CMD_TICK = 2'd0;
  localparam cmd_t CMD_SET_ROTATION = 2'd1;
  localparam cmd_t CMD_SET_TILT = 2'd2;

  localparam cfg_idx_t REG_ROTATION_MIN = 3'd0;
  localparam cfg_idx_t REG_ROTATION_MAX = 3'd1;
  localparam cfg_idx_t REG_TILT_MIN = 3'd2;
  localparam cfg_idx_t REG_TILT_MAX = 3'd3;
  localparam cfg_idx_t REG_STEP_SIZE = 3'd4;
  localparam cfg_idx_t REG_UPDATE_INTERVAL = 3'd5;
  localparam cfg_idx_t REG_PULSE_MIN = 3'd6;
  localparam cfg_idx_t REG_PULSE_MAX = 3'd7;

  localparam angle_t HOME_ANGLE = 12'd1440;
  localparam angle_t FULL_SCALE = 12'd2880;
  localparam angle_t STEP_RESET = 12'd16;
  localparam tick_t INTERVAL_RESET = 8'd20;
  localparam pulse_t PULSE_MIN_RESET = 12'd500;
  localparam pulse_t PULSE_MAX_RESET = 12'd2500;
  localparam tick_t TICK_SAT = 8'd255;
  localparam pulse_t PULSE_SAT = 12'd4095;

  // floor(n / 2880) = floor(((n + BIAS) >> 6) / 45) - BIAS_Q, with n + BIAS >= 0
  localparam int BIAS_Q = 5823;
  localparam int BIAS = BIAS_Q * 2880;
  localparam int PROD_W = 26;
  localparam int SHIFT_W = 19;
  localparam int QUOT_W = 14;
  localparam int RECIP_SHIFT = 26;
  localparam logic [20:0] RECIP_45 = 21'd1491308;
  localparam logic [5:0] DIV_45 = 6'd45;

endpackage

// ----- src/dual_axis_servo_slew_limiter_core.sv -----
// Dual axis servo slew limiter: set commands, tick counting, slewing and pulse scaling.
// Depends on dasl_pkg.
// Only a tick that moves an axis yields a result word, registered in s0, s1, s2, s3 and the output stage.
// Throughput: one input word per cycle; the five-stage pipeline advances as one,
// so a stalled output holds every stage and in_ready follows it.
// Reset: config registers to defaults, targets and positions to 1440, tick counter
// to 0, pipeline empty. Config writes are always ready.
module dual_axis_servo_slew_limiter_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dasl_pkg::cmd_t        cmd,
  input  dasl_pkg::target_t     target_angle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  rotation_moved,
  output dasl_pkg::pulse_t      rotation_pulse_us,
  output logic                  tilt_moved,
  output dasl_pkg::pulse_t      tilt_pulse_us,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  dasl_pkg::cfg_idx_t    cfg_index,
  input  dasl_pkg::cfg_data_t   cfg_data
);
  import dasl_pkg::*;

  angle_t rotation_min, rotation_max, tilt_min, tilt_max, step_size;
  tick_t update_interval;
  pulse_t pulse_min, pulse_max;

  angle_t rotation_target, rotation_position, tilt_target, tilt_position;
  tick_t ticks_since_update;
  angle_t rotation_target_next, rotation_position_next;
  angle_t tilt_target_next, tilt_position_next;
  tick_t ticks_since_update_next;

  logic advance;

  logic s0_valid;
  cmd_t s0_cmd;
  target_t s0_angle;

  logic fire;
  logic rot_moved_c, tilt_moved_c;
  angle_t rot_slew, tilt_slew, rot_clamp, tilt_clamp;
  tick_t ticks_inc;

  logic s1_valid, s1_rm, s1_tm;
  angle_t s1_rpos, s1_tpos;

  logic signed [PULSE_W:0] diff;
  logic s2_valid, s2_rm, s2_tm;
  logic signed [PROD_W-1:0] s2_rprod, s2_tprod;

  logic s3_valid, s3_rm, s3_tm;
  logic [SHIFT_W-1:0] s3_rm_shift, s3_tm_shift;
  logic [QUOT_W-1:0] s3_rqe, s3_tqe;

  function automatic angle_t clamp_window(target_t a, angle_t lo, angle_t hi);
    logic signed [TARGET_W:0] v;
    v = {a[TARGET_W-1], a};
    if (v < $signed({2'b00, lo})) v = $signed({2'b00, lo});
    if (v > $signed({2'b00, hi})) v = $signed({2'b00, hi});
    if (v < 0) v = '0;
    return v[ANGLE_W-1:0];
  endfunction

  function automatic angle_t slew(angle_t pos, angle_t tgt, angle_t step);
    logic [ANGLE_W:0] up;
    logic [ANGLE_W:0] reach;
    angle_t res;
    up = {1'b0, pos} + {1'b0, step};
    reach = {1'b0, tgt} + {1'b0, step};
    res = pos;
    if (tgt > pos) begin
      res = (up > {1'b0, tgt}) ? tgt : up[ANGLE_W-1:0];
    end else if (tgt < pos) begin
      res = ({1'b0, pos} >= reach) ? pos - step : tgt;
    end
    return res;
  endfunction

  function automatic logic [SHIFT_W-1:0] bias_shift(logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W:0] b;
    b = {prod[PROD_W-1], prod} + (PROD_W+1)'(BIAS);
    return b[SHIFT_W+5:6];
  endfunction

  function automatic logic [QUOT_W-1:0] quot_est(logic [SHIFT_W-1:0] m);
    logic [39:0] p;
    p = 40'(m) * 40'(RECIP_45);
    return p[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
  endfunction

  function automatic pulse_t pulse_final(logic [SHIFT_W-1:0] m, logic [QUOT_W-1:0] qe,
                                         pulse_t pmin);
    logic [SHIFT_W:0] back;
    logic [SHIFT_W:0] r;
    logic [QUOT_W-1:0] q;
    logic signed [15:0] p;
    back = (SHIFT_W+1)'(qe) * (SHIFT_W+1)'(DIV_45);
    r = {1'b0, m} - back;
    q = (r >= (SHIFT_W+1)'(DIV_45)) ? qe + 1'b1 : qe;
    p = $signed({4'b0, pmin}) + $signed({2'b0, q}) - 16'(BIAS_Q);
    if (p < 0) return '0;
    if (p > $signed({4'b0, PULSE_SAT})) return PULSE_SAT;
    return p[PULSE_W-1:0];
  endfunction

  assign advance = !out_valid || out_ready;
  assign in_ready = advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_min <= '0;
      rotation_max <= FULL_SCALE;
      tilt_min <= '0;
      tilt_max <= FULL_SCALE;
      step_size <= STEP_RESET;
      update_interval <= INTERVAL_RESET;
      pulse_min <= PULSE_MIN_RESET;
      pulse_max <= PULSE_MAX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROTATION_MIN: rotation_min <= cfg_data;
        REG_ROTATION_MAX: rotation_max <= cfg_data;
        REG_TILT_MIN: tilt_min <= cfg_data;
        REG_TILT_MAX: tilt_max <= cfg_data;
        REG_STEP_SIZE: step_size <= cfg_data;
        REG_UPDATE_INTERVAL: update_interval <= cfg_data[TICK_W-1:0];
        REG_PULSE_MIN: pulse_min <= cfg_data;
        REG_PULSE_MAX: pulse_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_cmd <= cmd;
      s0_angle <= target_angle;
    end
  end

  assign rot_clamp = clamp_window(s0_angle, rotation_min, rotation_max);
  assign tilt_clamp = clamp_window(s0_angle, tilt_min, tilt_max);
  assign rot_slew = slew(rotation_position, rotation_target, step_size);
  assign tilt_slew = slew(tilt_position, tilt_target, step_size);
  assign rot_moved_c = rot_slew != rotation_position;
  assign tilt_moved_c = tilt_slew != tilt_position;
  assign ticks_inc = (ticks_since_update == TICK_SAT) ? ticks_since_update
                                                      : ticks_since_update + 1'b1;

  always_comb begin
    rotation_target_next = rotation_target;
    tilt_target_next = tilt_target;
    rotation_position_next = rotation_position;
    tilt_position_next = tilt_position;
    ticks_since_update_next = ticks_since_update;
    fire = 1'b0;
    if (s0_valid) begin
      unique case (s0_cmd)
        CMD_SET_ROTATION: rotation_target_next = rot_clamp;
        CMD_SET_TILT: tilt_target_next = tilt_clamp;
        CMD_TICK: begin
          if (ticks_inc < update_interval) begin
            ticks_since_update_next = ticks_inc;
          end else begin
            ticks_since_update_next = '0;
            rotation_position_next = rot_slew;
            tilt_position_next = tilt_slew;
            fire = rot_moved_c || tilt_moved_c;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_target <= HOME_ANGLE;
      rotation_position <= HOME_ANGLE;
      tilt_target <= HOME_ANGLE;
      tilt_position <= HOME_ANGLE;
      ticks_since_update <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      rotation_target <= rotation_target_next;
      rotation_position <= rotation_position_next;
      tilt_target <= tilt_target_next;
      tilt_position <= tilt_position_next;
      ticks_since_update <= ticks_since_update_next;
      s1_valid <= fire;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  assign diff = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min});

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_rm <= rot_moved_c;
      s1_tm <= tilt_moved_c;
      s1_rpos <= rotation_position_next;
      s1_tpos <= tilt_position_next;

      s2_rm <= s1_rm;
      s2_tm <= s1_tm;
      s2_rprod <= PROD_W'($signed({1'b0, s1_rpos})) * PROD_W'(diff);
      s2_tprod <= PROD_W'($signed({1'b0, s1_tpos})) * PROD_W'(diff);

      s3_rm <= s2_rm;
      s3_tm <= s2_tm;
      s3_rm_shift <= bias_shift(s2_rprod);
      s3_tm_shift <= bias_shift(s2_tprod);
      s3_rqe <= quot_est(bias_shift(s2_rprod));
      s3_tqe <= quot_est(bias_shift(s2_tprod));

      rotation_moved <= s3_rm;
      tilt_moved <= s3_tm;
      rotation_pulse_us <= pulse_final(s3_rm_shift, s3_rqe, pulse_min);
      tilt_pulse_us <= pulse_final(s3_tm_shift, s3_tqe, pulse_min);
    end
  end

  a_result_has_move: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rotation_moved || tilt_moved))
    else $error("result word with no moved axis");

  a_rotation_moves_on_tick: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && (rotation_position != $past(rotation_position)))
    |-> $past(s0_valid && advance && (s0_cmd == CMD_TICK)))
    else $error("rotation position changed without a tick");

  a_tilt_moves_on_tick: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && (tilt_position != $past(tilt_position)))
    |-> $past(s0_valid && advance && (s0_cmd == CMD_TICK)))
    else $error("tilt position changed without a tick");

endmodule
